[rtl/bgd_pkg.sv]
package bgd_pkg;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int CFG_DW     = 13;
    localparam int CFG_IW     = 2;
    localparam int NUM_BANKS  = 6;
    localparam int BANK_W     = 3;
    localparam int KERN       = 5;

    // register defaults
    localparam int WIDTH_RESET  = 390;
    localparam int HEIGHT_RESET = 300;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_PHASE  = 2'd2;

    // request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [BANK_W-1:0] bank_t;
    typedef pix_t [KERN-1:0]   col_t;   // index 0 is the top row
    typedef col_t [KERN-1:0]   win_t;   // index 0 is the leftmost column

    // color site of the center pixel, {row parity, column parity}
    typedef enum logic [1:0] {
        SITE_GR = 2'b00,
        SITE_R  = 2'b01,
        SITE_B  = 2'b10,
        SITE_GB = 2'b11
    } site_t;

    // per-request control carried down the pipe
    typedef struct packed {
        logic  emit;
        logic  frame_end;
        logic  c_first;
        logic  c_second;
        logic  c_penult;
        logic  c_last;
        site_t site;
    } ctrl_t;

    // ring bank plus a small signed offset, modulo the bank count
    function automatic bank_t bank_add(bank_t b, logic signed [2:0] off);
        logic signed [4:0] s;
        s = $signed({2'b00, b}) + $signed({{2{off[2]}}, off});
        if (s < 5'sd0)
            s = s + 5'(NUM_BANKS);
        else if (s >= 5'(NUM_BANKS))
            s = s - 5'(NUM_BANKS);
        return s[BANK_W-1:0];
    endfunction

endpackage

[rtl/bgd_pix_if.sv]
interface bgd_pix_if;
    import bgd_pkg::*;

    logic valid;
    logic ready;
    logic opcode;
    pix_t raw_pixel;

    modport source (output valid, output opcode, output raw_pixel, input ready);
    modport sink (input valid, input opcode, input raw_pixel, output ready);
endinterface

[rtl/bgd_rgb_if.sv]
interface bgd_rgb_if;
    import bgd_pkg::*;

    logic valid;
    logic ready;
    pix_t red;
    pix_t green;
    pix_t blue;
    logic frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

[rtl/bgd_kernel.sv]
module bgd_kernel (
    input  bgd_pkg::win_t  win,
    input  bgd_pkg::site_t site,
    output bgd_pkg::pix_t  red,
    output bgd_pkg::pix_t  green,
    output bgd_pkg::pix_t  blue
);
    import bgd_pkg::*;

    typedef logic signed [13:0] acc_t;

    // round to nearest, divide by 16, clamp to 0..255
    function automatic pix_t finish(acc_t v);
        acc_t t;
        t = v + 14'sd8;
        if (t < 14'sd0)
            return '0;
        else if (t[13:4] > 10'd255)
            return 8'd255;
        else
            return t[11:4];
    endfunction

    function automatic acc_t px(pix_t p);
        return $signed({6'b000000, p});
    endfunction

    acc_t ctr;
    acc_t h1;
    acc_t v1;
    acc_t h2;
    acc_t v2;
    acc_t dg;
    acc_t g_at_rb;
    acc_t opp;
    acc_t horiz;
    acc_t vert;
    pix_t cv;

    // neighbor sums, win[column][row]
    assign ctr = px(win[2][2]);
    assign h1  = px(win[1][2]) + px(win[3][2]);
    assign v1  = px(win[2][1]) + px(win[2][3]);
    assign h2  = px(win[0][2]) + px(win[4][2]);
    assign v2  = px(win[2][0]) + px(win[2][4]);
    assign dg  = px(win[1][1]) + px(win[3][1]) + px(win[1][3]) + px(win[3][3]);
    assign cv  = win[2][2];

    // gradient-corrected kernels, scaled by 16
    assign g_at_rb = (ctr <<< 3) + ((h1 + v1) <<< 2) - ((h2 + v2) <<< 1);
    assign opp     = (ctr <<< 3) + (ctr <<< 2) + (dg <<< 2)
                   - ((h2 + v2) <<< 1) - (h2 + v2);
    assign horiz   = (ctr <<< 3) + (ctr <<< 1) + (h1 <<< 3) - (h2 <<< 1)
                   - (dg <<< 1) + v2;
    assign vert    = (ctr <<< 3) + (ctr <<< 1) + (v1 <<< 3) - (v2 <<< 1)
                   - (dg <<< 1) + h2;

    // pick per site
    always_comb
    begin
        case (site)
            SITE_R:
            begin
                red   = cv;
                green = finish(g_at_rb);
                blue  = finish(opp);
            end
            SITE_B:
            begin
                red   = finish(opp);
                green = finish(g_at_rb);
                blue  = cv;
            end
            SITE_GR:
            begin
                red   = finish(horiz);
                green = cv;
                blue  = finish(vert);
            end
            default:
            begin
                red   = finish(vert);
                green = cv;
                blue  = finish(horiz);
            end
        endcase
    end

endmodule

[rtl/bayer_gradient_demosaic.sv]
// Streaming 5x5 gradient-corrected Bayer demosaic.
// Requests arrive on the raw channel in raster order: opcode pixel carries a
// raw sample, opcode flush carries none. Full RGB pixels leave on the rgb
// channel in the same raster order, frame_end marking the last of a frame.
// The first result belongs to the request 2*width+2 of the frame; after all
// width*height pixels are in, each further request (flush or pixel) drains one
// result, so 2*width+2 of them empty the frame. Flushes before that are
// dropped. The user writes registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
// A write to width, height or phase restarts the frame counters. Throughput is
// one request per clock while the receiver does not stall. The edge that takes a
// request does its line-buffer read; the window shift follows, and then the
// kernel result is loaded into the output register.
// Six simple dual-port line memories (one write and one read per clock) of
// MAX_WIDTH samples hold the ring of rows.
// Reset clears counters and the pipeline; line memory is not cleared and is
// never read before it is written in the current frame.
// When the receiver stalls, the whole pipe holds and raw.ready drops; a
// request is still taken whenever the output register is empty or drained.
module bayer_gradient_demosaic #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [bgd_pkg::CFG_IW-1:0] cfg_index,
    input  logic [bgd_pkg::CFG_DW-1:0] cfg_data,
    bgd_pix_if.sink                raw,
    bgd_rgb_if.source              rgb
);
    import bgd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    // configuration
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [1:0]    phase_reg;
    logic [WW-1:0] w_sat;
    logic [HW-1:0] h_sat;
    logic          cfg_hit;

    // counters
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [HW-1:0] in_row_reg, in_row_next;
    bank_t         in_bank_reg, in_bank_next;
    logic [CW-1:0] f_col_reg, f_col_next;
    logic [HW-1:0] f_row_reg, f_row_next;
    bank_t         f_bank_reg, f_bank_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    // pipeline
    logic          adv;
    logic          acc;
    logic          draining;
    logic          is_pix;
    logic          wr;
    logic          fetch;
    logic          emit;
    logic          col_last;
    logic          row_last;
    logic          frame_last;
    logic [WW-1:0] w_m1;
    logic [WW-1:0] w_m2;
    logic [HW-1:0] h_m1;
    logic [HW-1:0] h_m2;
    ctrl_t         ctrl_now;
    bank_t         sel_now [KERN];

    logic          a_fetch_reg;
    ctrl_t         a_ctrl_reg;
    bank_t         a_sel_reg [KERN];
    logic          a_byp_reg;
    bank_t         a_wbank_reg;
    pix_t          a_pix_reg;
    pix_t          bank_rd [NUM_BANKS];

    col_t          new_col;
    win_t          s_reg;
    ctrl_t         b_ctrl_reg;
    win_t          win_m;

    logic          out_valid_reg;
    logic          out_end_reg;
    pix_t          out_r_reg, out_g_reg, out_b_reg;
    pix_t          k_r, k_g, k_b;

    // register writes saturate width and height
    always_comb
    begin
        if (cfg_data < CFG_DW'(4))
            w_sat = WW'(4);
        else if (32'(cfg_data) > MAX_WIDTH)
            w_sat = WW'(MAX_WIDTH);
        else
            w_sat = WW'(cfg_data);
        if (cfg_data < CFG_DW'(4))
            h_sat = HW'(4);
        else if (32'(cfg_data) > MAX_HEIGHT)
            h_sat = HW'(MAX_HEIGHT);
        else
            h_sat = HW'(cfg_data);
    end

    assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                                cfg_index == CFG_PHASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= WW'(W_RST);
            h_reg     <= HW'(H_RST);
            phase_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  w_reg     <= w_sat;
                CFG_HEIGHT: h_reg     <= h_sat;
                CFG_PHASE:  phase_reg <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // request decode
    assign w_m1     = w_reg - WW'(1);
    assign w_m2     = w_reg - WW'(2);
    assign h_m1     = h_reg - HW'(1);
    assign h_m2     = h_reg - HW'(2);
    assign adv      = !out_valid_reg || rgb.ready;
    assign raw.ready = adv;
    assign acc      = raw.valid && adv;
    assign draining = in_row_reg >= h_reg;
    assign is_pix   = raw.opcode == OP_PIXEL;
    assign wr       = acc && !draining && is_pix;
    assign fetch    = acc && (draining || (is_pix && in_row_reg >= HW'(2)));
    assign emit     = acc && (draining || (is_pix && (in_row_reg > HW'(2) ||
                      (in_row_reg == HW'(2) && in_col_reg >= CW'(2)))));
    assign col_last   = {1'b0, out_col_reg} == w_m1;
    assign row_last   = {1'b0, out_row_reg} == h_m1;
    assign frame_last = emit && col_last && row_last;

    // control for the pixel being emitted
    always_comb
    begin
        ctrl_now.emit      = emit;
        ctrl_now.frame_end = frame_last;
        ctrl_now.c_first   = out_col_reg == '0;
        ctrl_now.c_second  = out_col_reg == CW'(1);
        ctrl_now.c_penult  = {1'b0, out_col_reg} == w_m2;
        ctrl_now.c_last    = col_last;
        ctrl_now.site      = site_t'({out_row_reg[0] ^ phase_reg[1],
                                      out_col_reg[0] ^ phase_reg[0]});
    end

    // ring banks of the five window rows, mirrored at top and bottom
    always_comb
    begin
        sel_now[0] = bank_add(f_bank_reg, (f_row_reg == '0) ? 3'sd2 :
                              (f_row_reg == HW'(1)) ? 3'sd0 : -3'sd2);
        sel_now[1] = bank_add(f_bank_reg, (f_row_reg == '0) ? 3'sd1 : -3'sd1);
        sel_now[2] = f_bank_reg;
        sel_now[3] = bank_add(f_bank_reg, (f_row_reg == h_m1) ? -3'sd1 : 3'sd1);
        sel_now[4] = bank_add(f_bank_reg, (f_row_reg == h_m1) ? -3'sd2 :
                              (f_row_reg == h_m2) ? 3'sd0 : 3'sd2);
    end

    // counter updates
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_bank_next = in_bank_reg;
        f_col_next   = f_col_reg;
        f_row_next   = f_row_reg;
        f_bank_next  = f_bank_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit || frame_last)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_bank_next = '0;
            f_col_next   = '0;
            f_row_next   = '0;
            f_bank_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (wr)
            begin
                if ({1'b0, in_col_reg} == w_m1)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + HW'(1);
                    in_bank_next = bank_add(in_bank_reg, 3'sd1);
                end
                else
                    in_col_next = in_col_reg + CW'(1);
            end
            if (fetch)
            begin
                if ({1'b0, f_col_reg} == w_m1)
                begin
                    f_col_next  = '0;
                    f_row_next  = f_row_reg + HW'(1);
                    f_bank_next = bank_add(f_bank_reg, 3'sd1);
                end
                else
                    f_col_next = f_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                    out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_bank_reg <= '0;
            f_col_reg   <= '0;
            f_row_reg   <= '0;
            f_bank_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_bank_reg <= in_bank_next;
            f_col_reg   <= f_col_next;
            f_row_reg   <= f_row_next;
            f_bank_reg  <= f_bank_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line memories, one per ring row
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        pix_t mem [MAX_WIDTH];
        pix_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr && in_bank_reg == BANK_W'(b))
                mem[in_col_reg] <= raw.raw_pixel;
            if (adv)
                rd_reg <= mem[f_col_reg];
        end

        assign bank_rd[b] = rd_reg;
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_fetch_reg <= 1'b0;
            a_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            a_fetch_reg <= fetch;
            a_ctrl_reg  <= ctrl_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sel_reg   <= sel_now;
            a_byp_reg   <= wr;
            a_wbank_reg <= in_bank_reg;
            a_pix_reg   <= raw.raw_pixel;
        end
    end

    // new window column, rows in the bank being written take the new sample
    always_comb
    begin
        for (int j = 0; j < KERN; j++)
        begin
            if (a_byp_reg && a_sel_reg[j] == a_wbank_reg)
                new_col[j] = a_pix_reg;
            else
                new_col[j] = bank_rd[a_sel_reg[j]];
        end
    end

    // window shift
    always_ff @(posedge clk)
    begin
        if (adv && a_fetch_reg)
        begin
            for (int i = 0; i < KERN - 1; i++)
                s_reg[i] <= s_reg[i+1];
            s_reg[KERN-1] <= new_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctrl_reg <= '0;
        else if (adv)
            b_ctrl_reg <= a_ctrl_reg;
    end

    // left and right mirroring of window columns
    always_comb
    begin
        win_m[0] = b_ctrl_reg.c_first ? s_reg[4] :
                   b_ctrl_reg.c_second ? s_reg[2] : s_reg[0];
        win_m[1] = b_ctrl_reg.c_first ? s_reg[3] : s_reg[1];
        win_m[2] = s_reg[2];
        win_m[3] = b_ctrl_reg.c_last ? s_reg[1] : s_reg[3];
        win_m[4] = b_ctrl_reg.c_last ? s_reg[0] :
                   b_ctrl_reg.c_penult ? s_reg[2] : s_reg[4];
    end

    bgd_kernel u_kernel (
        .win   (win_m),
        .site  (b_ctrl_reg.site),
        .red   (k_r),
        .green (k_g),
        .blue  (k_b)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= b_ctrl_reg.emit;
            out_end_reg   <= b_ctrl_reg.frame_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg <= k_r;
            out_g_reg <= k_g;
            out_b_reg <= k_b;
        end
    end

    assign rgb.valid     = out_valid_reg;
    assign rgb.red       = out_r_reg;
    assign rgb.green     = out_g_reg;
    assign rgb.blue      = out_b_reg;
    assign rgb.frame_end = out_end_reg;

endmodule

[rtl/bgd_checker.sv]
module bgd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic frame_end
);

    // a result waiting on the receiver stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({red, green, blue, frame_end}))
        else $error("result changed while stalled");

    // an empty output register never blocks requests
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("requests blocked with empty output");

    // a drained output lets the pipe move
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("requests blocked while output drains");

endmodule

bind bayer_gradient_demosaic bgd_checker u_bgd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (raw.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue),
    .frame_end (rgb.frame_end)
);

[test/testbench.sv]
module testbench;
    import bgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX = 4096;
    localparam int SETTLE   = 12;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic op;
        pix_t px;
    } raw_req_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
        logic frame_end;
    } rgb_pix_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    bgd_pix_if raw ();
    bgd_rgb_if rgb ();

    bayer_gradient_demosaic uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (raw),
        .rgb       (rgb)
    );

    raw_req_t raw_pending[$];
    rgb_pix_t rgb_expected[$];

    // predictor state
    pix_t rows_seen [NUM_BANKS][LINE_MAX];
    int   wr_col, wr_row, rd_col, rd_row;
    int   reg_width, reg_height, reg_phase;

    int   n_taken;
    int   n_mismatch;
    int   n_fail;
    bit   took;
    bit   held_once;
    int   hold_left;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int sat_size(int v);
        if (v < 4)
            return 4;
        if (v > LINE_MAX)
            return LINE_MAX;
        return v;
    endfunction

    // reflect about the edge pixel
    function automatic int reflect(int i, int n);
        if (i < 0)
            i = -i;
        if (i > n - 1)
            i = 2 * (n - 1) - i;
        if (i < 0)
            i = 0;
        return i;
    endfunction

    // round, scale down by 16 and clamp to a byte
    function automatic pix_t kernel_out(int v);
        int t;
        t = v + 8;
        if (t < 0)
            return '0;
        t = t / 16;
        if (t > 255)
            t = 255;
        return pix_t'(t);
    endfunction

    function automatic void restart_frame();
        wr_col = 0;
        wr_row = 0;
        rd_col = 0;
        rd_row = 0;
    endfunction

    // interpolate the pixel at the read position and advance it
    function automatic void emit_rgb(int w, int h);
        int nb [5][5];
        int ctr, h1, v1, h2, v2, dg, g_rb, opp, horiz, vert;
        site_t s;
        rgb_pix_t p;
        for (int dy = -2; dy <= 2; dy++)
            for (int dx = -2; dx <= 2; dx++)
                nb[dy + 2][dx + 2] = rows_seen[reflect(rd_row + dy, h) % NUM_BANKS]
                                              [reflect(rd_col + dx, w)];
        ctr   = nb[2][2];
        h1    = nb[2][1] + nb[2][3];
        v1    = nb[1][2] + nb[3][2];
        h2    = nb[2][0] + nb[2][4];
        v2    = nb[0][2] + nb[4][2];
        dg    = nb[1][1] + nb[1][3] + nb[3][1] + nb[3][3];
        g_rb  = 8 * ctr + 4 * (h1 + v1) - 2 * (h2 + v2);
        opp   = 12 * ctr + 4 * dg - 3 * (h2 + v2);
        horiz = 10 * ctr + 8 * h1 - 2 * h2 - 2 * dg + v2;
        vert  = 10 * ctr + 8 * v1 - 2 * v2 - 2 * dg + h2;
        s = site_t'({1'(rd_row ^ (reg_phase >> 1)), 1'(rd_col ^ reg_phase)});
        case (s)
            SITE_R:  p = '{pix_t'(ctr), kernel_out(g_rb), kernel_out(opp), 1'b0};
            SITE_B:  p = '{kernel_out(opp), kernel_out(g_rb), pix_t'(ctr), 1'b0};
            SITE_GR: p = '{kernel_out(horiz), pix_t'(ctr), kernel_out(vert), 1'b0};
            default: p = '{kernel_out(vert), pix_t'(ctr), kernel_out(horiz), 1'b0};
        endcase
        if (rd_col + 1 >= w) begin
            rd_col = 0;
            if (rd_row + 1 >= h) begin
                p.frame_end = 1'b1;
                restart_frame();
            end
            else
                rd_row++;
        end
        else
            rd_col++;
        rgb_expected.push_back(p);
    endfunction

    // work out the result of one accepted request
    function automatic void predict_rgb(raw_req_t q);
        int w, h;
        w = sat_size(reg_width);
        h = sat_size(reg_height);
        if (wr_row < h) begin
            int r, c;
            r = wr_row;
            c = wr_col;
            if (q.op == OP_FLUSH)
                return;
            rows_seen[r % NUM_BANKS][c] = q.px;
            if (c + 1 >= w) begin
                wr_col = 0;
                wr_row = r + 1;
            end
            else
                wr_col = c + 1;
            if (r < 2 || (r == 2 && c < 2))
                return;
        end
        emit_rgb(w, h);
    endfunction

    // input acceptance feeds the predictor
    always @(posedge clk)
    begin
        took <= raw.valid && raw.ready;
        if (rst_n && raw.valid && raw.ready) begin
            predict_rgb('{raw.opcode, raw.raw_pixel});
            n_taken <= n_taken + 1;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        bit quiet;
        quiet = (n_taken >= 200 && n_taken < 320);
        if (rst_n && (!raw.valid || took)) begin
            if (raw_pending.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
                raw_req_t q;
                q = raw_pending.pop_front();
                raw.valid     <= 1'b1;
                raw.opcode    <= q.op;
                raw.raw_pixel <= q.px;
            end
            else
                raw.valid <= 1'b0;
        end
    end

    // receiver ready, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!held_once && n_taken >= 100) begin
                held_once <= 1'b1;
                hold_left <= 300;
                rgb.ready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rgb.ready <= (hold_left == 1);
            end
            else if (n_taken >= 200 && n_taken < 320)
                rgb.ready <= 1'b1;
            else
                rgb.ready <= ($urandom_range(99) >= 7);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rgb.valid && rgb.ready) begin
            if (rgb_expected.size() == 0) begin
                n_fail++;
                if (n_mismatch < 10)
                    $display("unexpected rgb result %h %h %h fe=%b",
                             rgb.red, rgb.green, rgb.blue, rgb.frame_end);
                n_mismatch++;
            end
            else begin
                rgb_pix_t e;
                e = rgb_expected.pop_front();
                if (e.red !== rgb.red || e.green !== rgb.green ||
                    e.blue !== rgb.blue || e.frame_end !== rgb.frame_end) begin
                    n_fail++;
                    if (n_mismatch < 10)
                        $display("rgb mismatch: expected %h %h %h fe=%b, got %h %h %h fe=%b",
                                 e.red, e.green, e.blue, e.frame_end,
                                 rgb.red, rgb.green, rgb.blue, rgb.frame_end);
                    n_mismatch++;
                end
            end
        end
    end

    function automatic pix_t rand_pix();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return pix_t'($urandom);
        endcase
    endfunction

    // one complete frame, with stray flushes and a pixel/flush drain
    function automatic void queue_frame(int w, int h);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < 5)
                raw_pending.push_back('{OP_FLUSH, pix_t'($urandom)});
            raw_pending.push_back('{OP_PIXEL, rand_pix()});
        end
        for (int i = 0; i < 2 * w + 2; i++)
            raw_pending.push_back('{logic'($urandom_range(1)), pix_t'($urandom)});
    endfunction

    task automatic wait_idle();
        while (raw_pending.size() > 0 || raw.valid || rgb_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DW'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_width = val & 13'h1fff;
            CFG_HEIGHT: reg_height = val & 13'h1fff;
            CFG_PHASE:  reg_phase = val & 3;
            default:    return;
        endcase
        restart_frame();
    endtask

    task automatic set_shape(int w, int h, int ph);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_PHASE, ph);
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        raw.valid     = 1'b0;
        raw.opcode    = OP_PIXEL;
        raw.raw_pixel = '0;
        rgb.ready     = 1'b1;
        took          = 1'b0;
        held_once     = 1'b0;
        hold_left     = 0;
        n_taken       = 0;
        n_mismatch    = 0;
        n_fail        = 0;
        reg_width     = WIDTH_RESET;
        reg_height    = HEIGHT_RESET;
        reg_phase     = 0;
        restart_frame();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: smallest frame, extreme samples, early flushes,
        // pixels during the drain
        set_shape(4, 4, 0);
        raw_pending.push_back('{OP_FLUSH, 8'h00});
        for (int i = 0; i < 16; i++) begin
            raw_pending.push_back('{OP_PIXEL, (i % 3 == 0) ? 8'hff : 8'h00});
            if (i == 7)
                raw_pending.push_back('{OP_FLUSH, 8'hff});
        end
        for (int i = 0; i < 10; i++)
            raw_pending.push_back('{logic'(i & 1), 8'hff});
        wait_idle();

        // unused register index leaves everything alone
        write_reg(CFG_UNUSED, 8191);

        // random frames over all phases, back to back pairs
        for (int k = 0; k < 4; k++) begin
            set_shape($urandom_range(4, 8), $urandom_range(4, 7), k % 4);
            queue_frame(sat_size(reg_width), sat_size(reg_height));
            queue_frame(sat_size(reg_width), sat_size(reg_height));
            wait_idle();
        end

        // width and height below the minimum saturate
        set_shape(2, 0, 1);
        queue_frame(4, 4);
        wait_idle();

        if (n_fail == 0 && rgb_expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // timeout
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/bgd_pkg.sv
rtl/bgd_pix_if.sv
rtl/bgd_rgb_if.sv
rtl/bgd_kernel.sv
rtl/bayer_gradient_demosaic.sv
rtl/bgd_checker.sv
test/testbench.sv
